// ===== hw/rtl/palette_colorize_downsample_macros.svh =====
// assertion macros for the palette colorizer checker
`ifndef PALETTE_COLORIZE_DOWNSAMPLE_MACROS_SVH
`define PALETTE_COLORIZE_DOWNSAMPLE_MACROS_SVH
`define PCD_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PCD_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/pcd_pkg.sv =====
// package: types and constants of the palette colorizer
package pcd_pkg;
    localparam int PALETTE_DEPTH = 4096;
    localparam int MAX_AA = 16;
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int SUM_W = 24;
    localparam int TOT_W = 9;
    localparam int CFG_IW = 3;

    localparam logic [CFG_IW-1:0] REG_LIMIT = 3'd0;
    localparam logic [CFG_IW-1:0] REG_ROT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_CEIL = 3'd2;
    localparam logic [CFG_IW-1:0] REG_SHIFT = 3'd3;
    localparam logic [CFG_IW-1:0] REG_SIZE = 3'd4;
    localparam logic [CFG_IW-1:0] REG_AA = 3'd5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [11:0] palette_address;
        logic [15:0] pal_red;
        logic [15:0] pal_green;
        logic [15:0] pal_blue;
        logic [31:0] iteration_count;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pixel_red;
        logic [15:0] pixel_green;
        logic [15:0] pixel_blue;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MOD, ST_READ, ST_ACC, ST_DIV, ST_OUT
    } state_t;
endpackage

// ===== hw/rtl/pcd_ram.sv =====
// generic single port ram with registered read
module pcd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/palette_colorize_downsample.sv =====
// top level: palette lookup, accumulation and box downsample
// sequence: a load is written to the palette from the idle state; an in-range sample
//   passes the bit-serial modulo (33 steps plus a final check) and the palette read; a
//   count at or above the limit skips both; a sample that ends a pixel adds the 24-step
//   divide of the three sums, the output register and the output transaction
// throughput: one transaction at a time; the next is taken when this one ends
// reset: async active low clears control, sums, count; inits config; palette not cleared
module palette_colorize_downsample
    import pcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IW-1:0]     cfg_index,
    input  logic [31:0]           cfg_data
);
    state_t state_reg, state_next;
    logic [31:0] limit_reg, rot_reg, ceil_reg;
    logic [4:0]  shift_reg, aa_reg;
    logic [12:0] size_reg;
    in_item_t    item_reg;
    logic [SUM_W-1:0] rs_reg, gs_reg, bs_reg;
    logic [8:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [32:0] dvd_reg;
    logic [5:0]  step_reg;
    logic [SUM_W-1:0] qr_reg, qg_reg, qb_reg;
    logic [SUM_W-1:0] dr_reg, dg_reg, db_reg;
    logic [TOT_W-1:0] rr_reg, rg_reg, rb_reg;
    logic        ov_reg;
    out_item_t   out_reg;
    logic [47:0] ram_rdata;
    logic        ram_we;
    logic [PAL_AW-1:0] ram_addr;

    logic [12:0] eff_size;
    logic [4:0]  eff_aa;
    logic [TOT_W-1:0] total;
    logic [32:0] rot_sum, clamped;
    logic [32:0] rem_sh;
    logic        accept, done_sample;
    logic [8:0]  cnt_inc;

    assign eff_size = (size_reg == 13'd0 || size_reg > 13'(PALETTE_DEPTH))
        ? 13'(PALETTE_DEPTH) : size_reg;
    assign eff_aa = (aa_reg == 5'd0) ? 5'd1 : (aa_reg > 5'(MAX_AA) ? 5'(MAX_AA) : aa_reg);
    assign total = {4'd0, eff_aa} * {4'd0, eff_aa};
    assign rot_sum = {1'b0, in_data.iteration_count} + {1'b0, rot_reg};
    assign clamped = (rot_sum >= {1'b0, ceil_reg}) ? {1'b0, ceil_reg - 32'd1} : rot_sum;
    assign rem_sh = {rem_reg[31:0], dvd_reg[32]};
    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data = out_reg;
    assign cnt_inc = cnt_reg + 9'd1;

    assign ram_we = accept && in_data.command == CMD_LOAD;
    assign ram_addr = ram_we ? in_data.palette_address[PAL_AW-1:0] : rem_reg[PAL_AW-1:0];
    assign done_sample = cnt_inc >= total;

    pcd_ram #(.WIDTH(48), .DEPTH(PALETTE_DEPTH)) u_pal (
        .clk(clk), .we(ram_we), .addr(ram_addr),
        .wdata({in_data.pal_red, in_data.pal_green, in_data.pal_blue}),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && in_data.command == CMD_SAMPLE)
                begin
                    state_next = (in_data.iteration_count < limit_reg) ? ST_MOD : ST_ACC;
                end
            ST_MOD:  if (step_reg == 6'd33) state_next = ST_READ;
            ST_READ: state_next = ST_ACC;
            ST_ACC:  state_next = done_sample ? ST_DIV : ST_IDLE;
            ST_DIV:  if (step_reg == 6'(SUM_W)) state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            limit_reg <= '1;
            rot_reg <= '0;
            ceil_reg <= '1;
            shift_reg <= '0;
            size_reg <= 13'd4096;
            aa_reg <= 5'd1;
            rs_reg <= '0;
            gs_reg <= '0;
            bs_reg <= '0;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LIMIT: limit_reg <= cfg_data;
                    REG_ROT:   rot_reg <= cfg_data;
                    REG_CEIL:  ceil_reg <= cfg_data;
                    REG_SHIFT: shift_reg <= cfg_data[4:0];
                    REG_SIZE:  size_reg <= cfg_data[12:0];
                    REG_AA:    aa_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (accept)
                    begin
                        item_reg <= in_data;
                        dvd_reg <= clamped >> shift_reg;
                        rem_reg <= '0;
                    end
                end
                ST_MOD:
                begin
                    if (step_reg != 6'd33)
                    begin
                        step_reg <= step_reg + 6'd1;
                        dvd_reg <= {dvd_reg[31:0], 1'b0};
                        rem_reg <= (rem_sh >= {20'd0, eff_size}) ? rem_sh - {20'd0, eff_size}
                                                                 : rem_sh;
                    end
                end
                ST_READ: ;
                ST_ACC:
                begin
                    step_reg <= '0;
                    if (item_reg.iteration_count < limit_reg)
                    begin
                        rs_reg <= rs_reg + SUM_W'(ram_rdata[47:32]);
                        gs_reg <= gs_reg + SUM_W'(ram_rdata[31:16]);
                        bs_reg <= bs_reg + SUM_W'(ram_rdata[15:0]);
                    end
                    cnt_reg <= cnt_inc;
                    dr_reg <= (item_reg.iteration_count < limit_reg)
                        ? rs_reg + SUM_W'(ram_rdata[47:32]) : rs_reg;
                    dg_reg <= (item_reg.iteration_count < limit_reg)
                        ? gs_reg + SUM_W'(ram_rdata[31:16]) : gs_reg;
                    db_reg <= (item_reg.iteration_count < limit_reg)
                        ? bs_reg + SUM_W'(ram_rdata[15:0]) : bs_reg;
                    rr_reg <= '0;
                    rg_reg <= '0;
                    rb_reg <= '0;
                end
                ST_DIV:
                begin
                    if (step_reg != 6'(SUM_W))
                    begin
                        step_reg <= step_reg + 6'd1;
                        dr_reg <= {dr_reg[SUM_W-2:0], 1'b0};
                        dg_reg <= {dg_reg[SUM_W-2:0], 1'b0};
                        db_reg <= {db_reg[SUM_W-2:0], 1'b0};
                        if ({rr_reg, dr_reg[SUM_W-1]} >= {1'b0, total})
                        begin
                            rr_reg <= TOT_W'({rr_reg, dr_reg[SUM_W-1]} - {1'b0, total});
                            qr_reg <= {qr_reg[SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rr_reg <= {rr_reg[TOT_W-2:0], dr_reg[SUM_W-1]};
                            qr_reg <= {qr_reg[SUM_W-2:0], 1'b0};
                        end
                        if ({rg_reg, dg_reg[SUM_W-1]} >= {1'b0, total})
                        begin
                            rg_reg <= TOT_W'({rg_reg, dg_reg[SUM_W-1]} - {1'b0, total});
                            qg_reg <= {qg_reg[SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rg_reg <= {rg_reg[TOT_W-2:0], dg_reg[SUM_W-1]};
                            qg_reg <= {qg_reg[SUM_W-2:0], 1'b0};
                        end
                        if ({rb_reg, db_reg[SUM_W-1]} >= {1'b0, total})
                        begin
                            rb_reg <= TOT_W'({rb_reg, db_reg[SUM_W-1]} - {1'b0, total});
                            qb_reg <= {qb_reg[SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rb_reg <= {rb_reg[TOT_W-2:0], db_reg[SUM_W-1]};
                            qb_reg <= {qb_reg[SUM_W-2:0], 1'b0};
                        end
                    end
                end
                ST_OUT:
                begin
                    ov_reg <= 1'b1;
                    out_reg <= '{pixel_red: qr_reg[15:0], pixel_green: qg_reg[15:0],
                                 pixel_blue: qb_reg[15:0]};
                    rs_reg <= '0;
                    gs_reg <= '0;
                    bs_reg <= '0;
                    cnt_reg <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== hw/rtl/pcd_checker.sv =====
// port checker for the palette colorizer, bound to the top level
`include "palette_colorize_downsample_macros.svh"
module pcd_checker
    import pcd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);
    logic out_stall;
    logic take_sample;

    assign out_stall = out_valid && !out_ready;
    assign take_sample = in_valid && in_ready && in_data.command == CMD_SAMPLE;

    `PCD_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data))
    `PCD_ASSERT_IMP(a_no_take_full, clk, rst_n, out_valid, !in_ready)
    `PCD_ASSERT_NXT(a_busy_after, clk, rst_n, take_sample, !in_ready)
endmodule

bind palette_colorize_downsample pcd_checker u_pcd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== test/testbench.sv =====
// testbench for the palette colorizer with box downsample
`timescale 1ns / 100ps

module testbench;
    import pcd_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    palette_colorize_downsample uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [47:0] pal_mem [PALETTE_DEPTH];
    bit pal_written [PALETTE_DEPTH];
    logic [23:0] acc_r, acc_g, acc_b;
    logic [8:0] acc_count;
    logic [31:0] lim_q, rot_q, ceil_q;
    logic [4:0] shift_q, aa_q;
    logic [12:0] size_q;

    out_item_t pixel_queue [$];
    int mismatches = 0;
    int errors = 0;
    bit idle_en = 1'b1;
    bit hold_off = 1'b0;

    function automatic int unsigned eff_size();
        if (size_q == 0 || size_q > PALETTE_DEPTH)
            return PALETTE_DEPTH;
        return size_q;
    endfunction

    function automatic int unsigned eff_aa();
        if (aa_q == 0)
            return 1;
        if (aa_q > MAX_AA)
            return MAX_AA;
        return aa_q;
    endfunction

    function automatic int unsigned lookup_index(logic [31:0] cnt);
        logic [32:0] v;
        v = {1'b0, cnt} + {1'b0, rot_q};
        if (v >= {1'b0, ceil_q})
            v = {1'b0, ceil_q - 32'd1};
        v = v >> shift_q;
        return int'(v % eff_size());
    endfunction

    task automatic predict_item(in_item_t it);
        int unsigned idx;
        int unsigned tot;
        out_item_t px;
        if (it.command == CMD_LOAD)
        begin
            pal_mem[it.palette_address] = {it.pal_red, it.pal_green, it.pal_blue};
            pal_written[it.palette_address] = 1'b1;
            return;
        end
        if (it.iteration_count < lim_q)
        begin
            idx = lookup_index(it.iteration_count);
            acc_r = acc_r + pal_mem[idx][47:32];
            acc_g = acc_g + pal_mem[idx][31:16];
            acc_b = acc_b + pal_mem[idx][15:0];
        end
        tot = eff_aa() * eff_aa();
        acc_count = acc_count + 9'd1;
        if (acc_count < tot)
            return;
        px.pixel_red = 16'(acc_r / tot);
        px.pixel_green = 16'(acc_g / tot);
        px.pixel_blue = 16'(acc_b / tot);
        pixel_queue.push_back(px);
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        acc_count = 0;
    endtask

    function automatic bit sample_safe(logic [31:0] cnt);
        if (cnt >= lim_q)
            return 1'b1;
        return pal_written[lookup_index(cnt)];
    endfunction

    // valid stays high after a transaction until the next idle or pause
    task automatic send_item(in_item_t it);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_item(it);
        @(negedge clk);
    endtask

    // waits until no transaction is in flight before writing
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
        in_valid <= 1'b0;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LIMIT: lim_q = val;
            REG_ROT: rot_q = val;
            REG_CEIL: ceil_q = val;
            REG_SHIFT: shift_q = val[4:0];
            REG_SIZE: size_q = val[12:0];
            REG_AA: aa_q = val[4:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pixel_queue.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (80) @(negedge clk);
    endtask

    task automatic load_entry(int unsigned a, logic [15:0] r, logic [15:0] g, logic [15:0] b);
        in_item_t it;
        it = '0;
        it.command = CMD_LOAD;
        it.palette_address = a[11:0];
        it.pal_red = r;
        it.pal_green = g;
        it.pal_blue = b;
        it.iteration_count = $urandom;
        send_item(it);
    endtask

    task automatic sample(logic [31:0] cnt);
        in_item_t it;
        it = '0;
        it.palette_address = 12'($urandom);
        it.pal_red = 16'($urandom);
        it.command = CMD_SAMPLE;
        it.iteration_count = cnt;
        send_item(it);
    endtask

    task automatic random_sample();
        logic [31:0] c;
        int tries;
        tries = 0;
        do
        begin
            case ($urandom_range(0, 3))
                0: c = $urandom_range(0, 64);
                1: c = $urandom;
                2: c = lim_q - 32'($urandom_range(0, 2));
                default: c = 32'hFFFFFFFF - 32'($urandom_range(0, 3));
            endcase
            tries++;
        end
        while (!sample_safe(c) && tries < 50);
        if (!sample_safe(c))
            c = 32'hFFFFFFFF;
        if (c >= lim_q || sample_safe(c))
            sample(c);
    endtask

    task automatic test_fill_palette();
        for (int a = 0; a < 128; a++)
            load_entry(a, 16'($urandom), 16'($urandom), 16'($urandom));
        drain();
    endtask

    task automatic test_directed();
        load_entry(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        load_entry(1, 16'h1234, 16'h8000, 16'hFFFF);
        load_entry(4095, 16'h0000, 16'hFFFF, 16'h0000);
        sample(0);
        sample(32'hFFFFFFFF);
        sample(4095);
        drain();
        write_reg(REG_AA, 16);
        for (int i = 0; i < 256; i++)
            sample(i[0] ? 32'd0 : 32'd4095);
        drain();
        write_reg(REG_AA, 0);
        write_reg(REG_CEIL, 0);
        write_reg(REG_ROT, 32'hFFFFFFFF);
        write_reg(REG_SHIFT, 31);
        write_reg(REG_SIZE, 0);
        write_reg(REG_LIMIT, 0);
        sample(32'h0);
        write_reg(REG_LIMIT, 32'hFFFFFFFF);
        sample(32'hFFFFFFFE);
        sample(32'h12345678);
        drain();
        write_reg(REG_SIZE, 1);
        write_reg(REG_SHIFT, 0);
        write_reg(REG_CEIL, 1);
        sample(32'd7);
        write_reg(REG_AA, 31);
        write_reg(REG_SIZE, 8191);
        write_reg(REG_AA, 2);
        write_reg(REG_SIZE, 4096);
        for (int i = 0; i < 4; i++)
            sample(32'($urandom));
        drain();
    endtask

    task automatic test_factor_change();
        write_reg(REG_AA, 3);
        for (int i = 0; i < 5; i++)
            sample(32'($urandom_range(0, 1000)));
        write_reg(REG_AA, 2);
        sample(32'd1);
        drain();
    endtask

    task automatic random_phase(int n);
        write_reg(REG_LIMIT, $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'hFFFFFFF0);
        write_reg(REG_ROT, $urandom);
        write_reg(REG_CEIL, $urandom_range(0, 1) ? 32'($urandom_range(0, 5000)) : 32'($urandom));
        write_reg(REG_SHIFT, $urandom_range(0, 31));
        write_reg(REG_SIZE, $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 8191))
                                                     : 32'($urandom_range(1, 128)));
        write_reg(REG_AA, $urandom_range(0, 4) == 0 ? 32'($urandom_range(0, 31)) : 32'($urandom_range(1, 3)));
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                load_entry($urandom_range(0, 4095), 16'($urandom), 16'($urandom),
                           16'($urandom));
            else
                random_sample();
        end
        // finish any partial pixel with a sample at or above the limit
        write_reg(REG_AA, 1);
        sample(32'hFFFFFFFF);
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(REG_AA, 1);
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                random_sample();
        join
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t ex;
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_queue.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected pixel %h", out_data);
                mismatches++;
            end
            else
            begin
                ex = pixel_queue.pop_front();
                if (out_data.pixel_red !== ex.pixel_red
                    || out_data.pixel_green !== ex.pixel_green
                    || out_data.pixel_blue !== ex.pixel_blue)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("pixel mismatch exp %h %h %h got %h %h %h",
                            ex.pixel_red, ex.pixel_green, ex.pixel_blue,
                            out_data.pixel_red, out_data.pixel_green, out_data.pixel_blue);
                    mismatches++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #400ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        acc_count = 0;
        lim_q = 32'hFFFFFFFF;
        rot_q = 0;
        ceil_q = 32'hFFFFFFFF;
        shift_q = 0;
        size_q = 4096;
        aa_q = 1;
        foreach (pal_written[i])
            pal_written[i] = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);
        test_directed();
        test_factor_change();
        test_fill_palette();
        test_backpressure();
        for (int p = 0; p < 5; p++)
            random_phase(100);
        idle_en = 1'b0;
        random_phase(100);
        if (pixel_queue.size() != 0)
            errors++;
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
